### sv/tcf_pkg.sv
// Shared types and constants of the trajectory coring filter.
`timescale 1ns / 1ps

package tcf_pkg;

    localparam int LABEL_W = 8;
    localparam int WIN_W   = 7;
    localparam int CNT_W   = 7;

    // One burst of results: first the non-core frames, then the core frames.
    typedef struct packed {
        logic [CNT_W-1:0]   nc_count;
        logic [LABEL_W-1:0] nc_label;
        logic [CNT_W-1:0]   co_count;
        logic [LABEL_W-1:0] co_label;
    } t_burst;

endpackage

### sv/tcf_window_table.sv
// Per-state window table with valid bits and a registered read port.
`timescale 1ns / 1ps

module tcf_window_table #(
    parameter int NUM_STATES = 256,
    parameter int MAX_WINDOW = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic                        i_rd_en,
    input  logic [tcf_pkg::LABEL_W-1:0] i_label,
    input  logic [tcf_pkg::WIN_W-1:0]   i_value,
    output logic [tcf_pkg::WIN_W-1:0]   o_window
);
    import tcf_pkg::*;

    localparam int LABEL_SPAN  = 1 << LABEL_W;
    localparam int TABLE_DEPTH = (NUM_STATES < LABEL_SPAN) ? NUM_STATES : LABEL_SPAN;
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int WIN_MAX_CODE = (1 << WIN_W) - 1;
    localparam logic [WIN_W-1:0] WIN_CAP =
        (MAX_WINDOW > WIN_MAX_CODE) ? WIN_W'(WIN_MAX_CODE) : WIN_W'(MAX_WINDOW);

    logic [WIN_W-1:0]       r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [WIN_W-1:0]       r_rd_data;
    logic                   r_rd_hit;
    logic                   in_range;
    logic [AW-1:0]          idx;
    logic [WIN_W-1:0]       capped;

    assign in_range = (32'(i_label) < 32'(NUM_STATES));
    assign idx      = i_label[AW-1:0];
    assign capped   = (i_value > WIN_CAP) ? WIN_CAP : i_value;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range) begin
            r_mem[idx] <= capped;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[idx];
        end
    end

    // An entry never written reads as the reset window of one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en && in_range) begin
                r_valid[idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= in_range && r_valid[idx];
            end
        end
    end

    // A zero window behaves like a window of one.
    assign o_window = (r_rd_hit && (r_rd_data != '0)) ? r_rd_data : WIN_W'(1);

endmodule

### sv/tcf_emitter.sv
// Result register that plays out one burst, one beat per cycle while the receiver is ready.
`timescale 1ns / 1ps

module tcf_emitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  tcf_pkg::t_burst             i_burst,
    input  logic                        i_m_tready,
    output logic                        o_tvalid,
    output logic [tcf_pkg::LABEL_W-1:0] o_label,
    output logic                        o_core,
    output logic                        o_last,
    output logic                        o_free
);
    import tcf_pkg::*;

    logic [CNT_W-1:0]   r_nc_count;
    logic [CNT_W-1:0]   r_co_count;
    logic [LABEL_W-1:0] r_nc_label;
    logic [LABEL_W-1:0] r_co_label;
    logic               nc_left;
    logic               beat;

    assign nc_left  = (r_nc_count != '0);
    assign o_tvalid = nc_left || (r_co_count != '0);
    assign o_label  = nc_left ? r_nc_label : r_co_label;
    assign o_core   = !nc_left;
    assign o_last   = ((r_nc_count == CNT_W'(1)) && (r_co_count == '0)) ||
                      ((r_nc_count == '0) && (r_co_count == CNT_W'(1)));
    assign beat     = o_tvalid && i_m_tready;
    // Free when empty, or when the final beat of the burst leaves this cycle.
    assign o_free   = !o_tvalid || (o_last && i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc_count <= '0;
            r_co_count <= '0;
        end else if (i_load) begin
            r_nc_count <= i_burst.nc_count;
            r_co_count <= i_burst.co_count;
        end else if (beat) begin
            if (nc_left) begin
                r_nc_count <= r_nc_count - CNT_W'(1);
            end else begin
                r_co_count <= r_co_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_nc_label <= i_burst.nc_label;
            r_co_label <= i_burst.co_label;
        end
    end

endmodule

### sv/trajectory_coring_filter.sv
// Top level of the trajectory coring filter.
`timescale 1ns / 1ps

// Dynamic coring of a state trajectory. Each frame beat carries a state label
// and a segment-end flag on tlast; a beat with tuser high instead writes the
// window length of one state. A frame is decided in a single registered pass:
// the window table is read when the beat is accepted, the decision is taken on
// the registered frame once the output register is free, and the resulting
// burst goes to the output register, which gives one result beat per cycle
// while the receiver is ready. Input is taken every cycle while each frame
// produces at most one result and the receiver is ready; a frame that releases
// more results holds input until the last beat of its burst leaves. Window
// writes are taken whenever input is ready and return no result. The window
// table is a memory of min(NUM_STATES, 256) entries with one valid bit per
// entry, so no clearing pass is needed after reset.
module trajectory_coring_filter #(
    parameter int NUM_STATES = 256,
    parameter int MAX_WINDOW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [7:0] frame_state, [14:8] window_value, [15] zero
    input  logic        i_s_tuser,  // [0] mode
    input  logic        i_s_tlast,  // segment_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [7:0] cored_state
    output logic        o_m_tuser,  // [0] is_core
    output logic        o_m_tlast   // last_of_burst
);
    import tcf_pkg::*;

    logic               s_accept;
    logic               fire;
    logic               emit_free;
    logic [WIN_W-1:0]   window;

    logic               r_fv;
    logic [LABEL_W-1:0] r_label;
    logic               r_seg_end;

    logic [LABEL_W-1:0] r_run_label;
    logic [CNT_W-1:0]   r_pend;
    logic [LABEL_W-1:0] r_core_label;
    logic               r_at_start;

    logic [LABEL_W-1:0] n_run_label;
    logic [CNT_W-1:0]   n_pend;
    logic [LABEL_W-1:0] n_core_label;
    logic [CNT_W-1:0]   pend_base;
    logic [CNT_W-1:0]   pend_inc;
    t_burst             burst;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign fire       = r_fv && emit_free;
    assign o_s_tready = !r_fv || fire;

    tcf_window_table #(
        .NUM_STATES(NUM_STATES),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (s_accept && i_s_tuser),
        .i_rd_en (s_accept && !i_s_tuser),
        .i_label (i_s_tdata[7:0]),
        .i_value (i_s_tdata[14:8]),
        .o_window(window)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (s_accept && !i_s_tuser) begin
            r_fv <= 1'b1;
        end else if (fire) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && !i_s_tuser) begin
            r_label   <= i_s_tdata[7:0];
            r_seg_end <= i_s_tlast;
        end
    end

    // Decision for the registered frame.
    always_comb begin
        n_run_label    = r_run_label;
        n_core_label   = r_core_label;
        pend_base      = r_pend;
        burst.nc_count = '0;
        burst.nc_label = r_core_label;
        if (r_at_start) begin
            n_core_label = r_label;
            n_run_label  = r_label;
            pend_base    = '0;
        end else if (r_label != r_run_label) begin
            // The old run was too short: its frames are reassigned.
            burst.nc_count = r_pend;
            pend_base      = '0;
            n_run_label    = r_label;
        end
        pend_inc = pend_base + CNT_W'(1);
        if (r_seg_end) begin
            burst.co_count = pend_inc;
            n_pend         = '0;
        end else if (pend_inc >= window) begin
            burst.co_count = pend_inc - window + CNT_W'(1);
            n_pend         = window - WIN_W'(1);
        end else begin
            burst.co_count = '0;
            n_pend         = pend_inc;
        end
        if (burst.co_count != '0) begin
            n_core_label = n_run_label;
        end
        burst.co_label = n_run_label;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_label  <= '0;
            r_pend       <= '0;
            r_core_label <= '0;
            r_at_start   <= 1'b1;
        end else if (fire) begin
            r_run_label  <= n_run_label;
            r_pend       <= n_pend;
            r_core_label <= n_core_label;
            r_at_start   <= r_seg_end;
        end
    end

    tcf_emitter u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (fire),
        .i_burst   (burst),
        .i_m_tready(i_m_tready),
        .o_tvalid  (o_m_tvalid),
        .o_label   (o_m_tdata),
        .o_core    (o_m_tuser),
        .o_last    (o_m_tlast),
        .o_free    (emit_free)
    );

    // A segment opens with nothing pending.
    a_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_at_start |-> (r_pend == '0))
        else $error("pending frames at segment start");

    // A segment end closes the segment after its frame is decided.
    a_seg_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_seg_end |=> r_at_start && (r_pend == '0))
        else $error("segment end did not reset the run");

    // Core beats always carry the current core label.
    a_core_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata == r_core_label))
        else $error("core beat with a stale core label");

endmodule

### tb/trajectory_coring_filter_tb.sv
// Self-checking testbench for the trajectory coring filter.
`timescale 1ns / 1ps

module trajectory_coring_filter_tb;
    import tcf_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int WINDOW_LIMIT = 64;
    localparam int ITEM_TARGET  = 320;
    localparam int QUIET_AFTER  = 270;
    localparam int IDLE_LIMIT   = 2000;
    localparam int POOL_SIZE    = 6;

    localparam logic MODE_FRAME  = 1'b0;
    localparam logic MODE_WINDOW = 1'b1;

    typedef struct packed {
        logic [LABEL_W-1:0] cored_state;
        logic               is_core;
        logic               last_of_burst;
    } t_core_result;

    // Tracks the coring state and keeps the results that are still owed.
    class coring_scoreboard;
        logic [WIN_W-1:0]   window_tbl [TABLE_DEPTH];
        logic [LABEL_W-1:0] run_label;
        logic [CNT_W-1:0]   pending;
        logic [LABEL_W-1:0] core_label;
        logic               seg_start;
        t_core_result       expected_q [$];
        int errors, frames, writes, segments, results, bursts, longest_burst;

        function new();
            foreach (window_tbl[i]) window_tbl[i] = 1;
            run_label     = '0;
            pending       = '0;
            core_label    = '0;
            seg_start     = 1'b1;
            errors        = 0;
            frames        = 0;
            writes        = 0;
            segments      = 0;
            results       = 0;
            bursts        = 0;
            longest_burst = 0;
        endfunction

        function int window_of(logic [LABEL_W-1:0] label);
            return (window_tbl[label] == 0) ? 1 : int'(window_tbl[label]);
        endfunction

        function void push_result(logic core);
            t_core_result r;
            r.cored_state   = core_label;
            r.is_core       = core;
            r.last_of_burst = 1'b0;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void note_beat(logic mode, logic [LABEL_W-1:0] label,
                                logic [WIN_W-1:0] win_value, logic seg_end);
            int produced;
            int win;
            produced = 0;
            if (mode == MODE_WINDOW) begin
                window_tbl[label] = (win_value > WINDOW_LIMIT) ? WIN_W'(WINDOW_LIMIT) : win_value;
                writes++;
                return;
            end
            frames++;
            if (seg_start) begin
                core_label = label;
                run_label  = label;
                pending    = '0;
                seg_start  = 1'b0;
            end else if (label != run_label) begin
                // The old run never reached its window, so its frames are reassigned.
                while (pending > 0) begin
                    push_result(1'b0);
                    pending--;
                    produced++;
                end
                run_label = label;
            end
            pending++;
            win = window_of(run_label);
            while (pending >= win) begin
                core_label = run_label;
                push_result(1'b1);
                pending--;
                produced++;
            end
            if (seg_end) begin
                segments++;
                while (pending > 0) begin
                    core_label = run_label;
                    push_result(1'b1);
                    pending--;
                    produced++;
                end
                seg_start = 1'b1;
            end
            if (produced > 0) begin
                expected_q[expected_q.size() - 1].last_of_burst = 1'b1;
                bursts++;
                if (produced > longest_burst) longest_burst = produced;
            end
        endfunction

        function void check_beat(logic [LABEL_W-1:0] cored_state, logic is_core,
                                 logic last_of_burst);
            t_core_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat: state %0d core %0d last %0d",
                         $time, cored_state, is_core, last_of_burst);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            results++;
            if (cored_state !== exp_r.cored_state) begin
                $display("%0t: cored_state mismatch: expected %0d, actual %0d",
                         $time, exp_r.cored_state, cored_state);
                errors++;
            end
            if (is_core !== exp_r.is_core) begin
                $display("%0t: is_core mismatch: expected %0d, actual %0d",
                         $time, exp_r.is_core, is_core);
                errors++;
            end
            if (last_of_burst !== exp_r.last_of_burst) begin
                $display("%0t: last_of_burst mismatch: expected %0d, actual %0d",
                         $time, exp_r.last_of_burst, last_of_burst);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // [7:0] frame_state, [14:8] window_value, [15] zero
    logic        i_s_tuser;   // [0] mode
    logic        i_s_tlast;   // segment_end
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // [7:0] cored_state
    logic        o_m_tuser;   // [0] is_core
    logic        o_m_tlast;   // last_of_burst

    coring_scoreboard sb = new();
    int items_sent;
    int idle_cycles;
    bit quiet;
    logic [LABEL_W-1:0] label_pool [POOL_SIZE];

    trajectory_coring_filter #(
        .NUM_STATES(TABLE_DEPTH),
        .MAX_WINDOW(WINDOW_LIMIT)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .o_m_tlast(o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result beats are sampled at the rising edge, before any register update.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_beat(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver backpressure in random bursts, switched off near the end.
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic mode, input logic [LABEL_W-1:0] label,
                             input logic [WIN_W-1:0] win_value, input logic seg_end);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tlast  <= seg_end;
        i_s_tdata  <= {1'b0, win_value, label};
        forever begin
            @(posedge i_clk);
            if (o_s_tready) break;
        end
        sb.note_beat(mode, label, win_value, seg_end);
        items_sent++;
        if (items_sent >= QUIET_AFTER) quiet = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [LABEL_W-1:0] label, input logic seg_end);
        send_beat(MODE_FRAME, label, WIN_W'($urandom), seg_end);
    endtask

    task automatic write_window(input logic [LABEL_W-1:0] label,
                                input logic [WIN_W-1:0] win_value);
        send_beat(MODE_WINDOW, label, win_value, 1'(($urandom)));
    endtask

    function automatic logic [WIN_W-1:0] random_window();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 12) return WIN_W'($urandom_range(0, 6));
        if (pick < 14) return WIN_W'($urandom_range(7, WINDOW_LIMIT));
        return WIN_W'($urandom_range(WINDOW_LIMIT, 127));
    endfunction

    // One run of a pooled label, sometimes with a window rewrite in the middle.
    task automatic send_run();
        logic [LABEL_W-1:0] label;
        int win;
        int run_len;
        label = label_pool[$urandom_range(0, POOL_SIZE - 1)];
        win = sb.window_of(label);
        run_len = $urandom_range(1, win + 2);
        if (win > 16 && $urandom_range(0, 3) != 0) run_len = $urandom_range(1, 8);
        for (int k = 0; k < run_len && items_sent < ITEM_TARGET; k++) begin
            if ($urandom_range(0, 19) == 0) write_window(label, WIN_W'($urandom_range(0, 3)));
            send_frame(label, (k == run_len - 1) ? ($urandom_range(0, 5) == 0)
                                                 : ($urandom_range(0, 39) == 0));
        end
    endtask

    initial begin
        int pick;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = MODE_FRAME;
        i_s_tlast  = 1'b0;
        items_sent = 0;
        idle_cycles = 0;
        quiet      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: clamped, zero and mid-size windows, label changes,
        // runs cut by a segment end and a window that shrinks during a run.
        write_window(8'hFF, 7'd127);
        write_window(8'h00, 7'd0);
        write_window(8'h05, 7'd3);
        write_window(8'hAA, 7'd64);
        repeat (4) send_frame(8'h05, 1'b0);
        send_frame(8'h07, 1'b0);
        send_frame(8'h00, 1'b0);
        send_frame(8'hFF, 1'b0);
        send_frame(8'hFF, 1'b0);
        send_frame(8'hFF, 1'b1);
        send_frame(8'hAA, 1'b0);
        send_frame(8'hAA, 1'b0);
        send_frame(8'h55, 1'b0);
        send_frame(8'h05, 1'b0);
        send_frame(8'h05, 1'b0);
        write_window(8'h05, 7'd1);
        send_frame(8'h05, 1'b0);
        send_frame(8'h55, 1'b1);

        // Random part: mostly runs of a few pooled labels, plus noise.
        label_pool[0] = 8'h00;
        label_pool[1] = 8'hFF;
        for (int i = 2; i < POOL_SIZE; i++) label_pool[i] = LABEL_W'($urandom);
        foreach (label_pool[i]) write_window(label_pool[i], WIN_W'($urandom_range(1, 5)));
        // Force one full-length window run early so the longest bursts appear.
        write_window(label_pool[2], WIN_W'(WINDOW_LIMIT));
        repeat (WINDOW_LIMIT - 1) send_frame(label_pool[2], 1'b0);
        send_frame(label_pool[3], 1'b0);

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                write_window(label_pool[$urandom_range(0, POOL_SIZE - 1)], random_window());
            end else if (pick == 1) begin
                if ($urandom_range(0, 1) == 0) write_window(LABEL_W'($urandom), random_window());
                else send_frame(LABEL_W'($urandom), 1'($urandom));
            end else begin
                send_run();
            end
        end
        i_s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
            sb.errors += sb.expected_q.size();
        end

        $display("Covered %0d frames, %0d window writes and %0d segment ends;",
                 sb.frames, sb.writes, sb.segments);
        $display("checked %0d results in %0d bursts, longest burst %0d.",
                 sb.results, sb.bursts, sb.longest_burst);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
